### rtl/mntp_pkg.sv
// Shared types, constants and the pitch table of the note word parser.
package mntp_pkg;

  // Parse phases of the front end
  typedef enum logic [3:0] {
    PH_LETTER = 4'd0,
    PH_ACC    = 4'd1,
    PH_OCT    = 4'd2,
    PH_SLASH  = 4'd3,
    PH_FRAC1  = 4'd4,
    PH_FRAC2  = 4'd5,
    PH_DOT    = 4'd6,
    PH_TIE    = 4'd7,
    PH_DONE   = 4'd8,
    PH_ERR    = 4'd9
  } phase_t;

  // Back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIVT = 2'd1,
    BK_FIN  = 2'd2,
    BK_OUT  = 2'd3
  } back_state_t;

  // Error codes
  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_ACC   = 3'd1;
  localparam logic [2:0] ERR_NAME  = 3'd2;
  localparam logic [2:0] ERR_OCT   = 3'd3;
  localparam logic [2:0] ERR_SLASH = 3'd4;
  localparam logic [2:0] ERR_FRAC  = 3'd5;

  // Accidental columns of the pitch table
  localparam logic [1:0] ACC_NAT   = 2'd0;
  localparam logic [1:0] ACC_FLAT  = 2'd1;
  localparam logic [1:0] ACC_SHARP = 2'd2;

  // Characters
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_FLAT  = 8'h62;
  localparam logic [7:0] CH_SHARP = 8'h23;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_TIE   = 8'h5F;

  // Widths
  localparam int PITCH_W = 12;
  localparam int OCT_W   = 4;
  localparam int FRAC_W  = 7;
  localparam int FREQ_W  = 13;
  localparam int WN_W    = 18;
  localparam int MS_W    = 19;
  localparam int ERR_W   = 3;

  // Fraction divider: numerator width, two quotient bits a cycle
  localparam int DIV_W     = WN_W;
  localparam int DIV_CYC   = DIV_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_CYC);

  // Divide by 100 as a multiply by ceil(2^27 / 100); exact below 2^20
  localparam int HZ_NUM_W   = 20;
  localparam int HZ_RECIP_W = 21;
  localparam int HZ_PROD_W  = HZ_NUM_W + HZ_RECIP_W;
  localparam int HZ_SHIFT   = 27;
  localparam logic [HZ_RECIP_W-1:0] HZ_RECIP = 21'd1342178;

  localparam logic [WN_W-1:0] WN_RESET = 18'd2000;

  // Parsed note word handed from front to back
  typedef struct packed {
    logic [PITCH_W-1:0] base;
    logic [OCT_W-1:0]   oct;
    logic [FRAC_W-1:0]  frac;
    logic               dotted;
    logic               tied;
    logic [ERR_W-1:0]   err;
  } note_cmd_t;

  // Divider request
  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  num;
    logic [FRAC_W-1:0] den;
  } div_req_t;

  // Base pitch in centihertz; 0 marks a forbidden accidental
  function automatic logic [PITCH_W-1:0] pitch_lookup(input logic [2:0] letter,
                                                      input logic [1:0] col);
    logic [PITCH_W-1:0] p;
    p = '0;
    unique case (letter)
      3'd0: p = (col == ACC_NAT) ? 12'd2750 : (col == ACC_FLAT) ? 12'd2596 : 12'd2914;
      3'd1: p = (col == ACC_NAT) ? 12'd3087 : (col == ACC_FLAT) ? 12'd2914 : 12'd0;
      3'd2: p = (col == ACC_NAT) ? 12'd1635 : (col == ACC_FLAT) ? 12'd0    : 12'd1732;
      3'd3: p = (col == ACC_NAT) ? 12'd1835 : (col == ACC_FLAT) ? 12'd1732 : 12'd1945;
      3'd4: p = (col == ACC_NAT) ? 12'd2060 : (col == ACC_FLAT) ? 12'd1945 : 12'd0;
      3'd5: p = (col == ACC_NAT) ? 12'd2183 : (col == ACC_FLAT) ? 12'd0    : 12'd2312;
      3'd6: p = (col == ACC_NAT) ? 12'd2450 : (col == ACC_FLAT) ? 12'd2312 : 12'd2596;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

### rtl/mntp_if.sv
// Valid/ready channel interfaces for characters in and note results out.
interface mntp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;
  modport source(output valid, output char_code, output last_char, input ready);
  modport sink(input valid, input char_code, input last_char, output ready);
endinterface

interface mntp_note_if;
  logic        valid;
  logic        ready;
  logic [12:0] frequency_hz;
  logic [18:0] slot_ms;
  logic [18:0] on_ms;
  logic [2:0]  error_code;
  modport source(output valid, output frequency_hz, output slot_ms, output on_ms,
                 output error_code, input ready);
  modport sink(input valid, input frequency_hz, input slot_ms, input on_ms,
               input error_code, output ready);
endinterface

### rtl/mntp_front.sv
// Front end: takes the characters of a note word one at a time and parses the note word.
module mntp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                char_valid,
  input  logic [7:0]          char_code,
  input  logic                last_char,
  input  logic                q_full,
  output logic                char_ready,
  output logic                push,
  output mntp_pkg::note_cmd_t push_cmd
);

  mntp_pkg::phase_t                 phase_r, phase_nxt;
  logic [2:0]                       letter_r, letter_nxt;
  logic [mntp_pkg::PITCH_W-1:0]     base_r, base_nxt;
  logic [mntp_pkg::OCT_W-1:0]       oct_r, oct_nxt;
  logic [mntp_pkg::FRAC_W-1:0]      frac_r, frac_nxt;
  logic                             dot_r, dot_nxt;
  logic                             tie_r, tie_nxt;
  logic [mntp_pkg::ERR_W-1:0]       err_r, err_nxt;
  logic                             take;
  logic                             fall_oct, fall_dot, fall_tie;
  logic [mntp_pkg::PITCH_W-1:0]     acc_pitch;
  logic [mntp_pkg::ERR_W-1:0]       end_err;
  logic                             is_digit;

  assign take       = char_valid && char_ready;
  assign char_ready = !q_full;
  assign is_digit   = (char_code >= mntp_pkg::CH_ZERO) && (char_code <= mntp_pkg::CH_NINE);
  assign acc_pitch  = mntp_pkg::pitch_lookup(letter_r,
                        (char_code == mntp_pkg::CH_FLAT) ? mntp_pkg::ACC_FLAT
                                                         : mntp_pkg::ACC_SHARP);

  // Next parse state: a character may fall through optional fields
  always_comb begin
    phase_nxt  = phase_r;
    letter_nxt = letter_r;
    base_nxt   = base_r;
    oct_nxt    = oct_r;
    frac_nxt   = frac_r;
    dot_nxt    = dot_r;
    tie_nxt    = tie_r;
    err_nxt    = err_r;
    fall_oct   = 1'b0;
    fall_dot   = 1'b0;
    fall_tie   = 1'b0;
    if (take) begin
      unique case (phase_r)
        mntp_pkg::PH_LETTER: begin
          if (char_code >= mntp_pkg::CH_A && char_code <= mntp_pkg::CH_G) begin
            letter_nxt = 3'(char_code - mntp_pkg::CH_A);
            base_nxt   = mntp_pkg::pitch_lookup(3'(char_code - mntp_pkg::CH_A),
                                                mntp_pkg::ACC_NAT);
            phase_nxt  = mntp_pkg::PH_ACC;
          end else if (char_code == mntp_pkg::CH_R) begin
            base_nxt  = '0;
            phase_nxt = mntp_pkg::PH_SLASH;
          end else begin
            err_nxt   = mntp_pkg::ERR_NAME;
            phase_nxt = mntp_pkg::PH_ERR;
          end
        end
        mntp_pkg::PH_ACC: begin
          if (char_code == mntp_pkg::CH_FLAT || char_code == mntp_pkg::CH_SHARP) begin
            if (acc_pitch == '0) begin
              err_nxt   = mntp_pkg::ERR_ACC;
              phase_nxt = mntp_pkg::PH_ERR;
            end else begin
              base_nxt  = acc_pitch;
              phase_nxt = mntp_pkg::PH_OCT;
            end
          end else begin
            fall_oct = 1'b1;
          end
        end
        mntp_pkg::PH_OCT: fall_oct = 1'b1;
        mntp_pkg::PH_SLASH: begin
          if (char_code == mntp_pkg::CH_SLASH) begin
            phase_nxt = mntp_pkg::PH_FRAC1;
          end else begin
            err_nxt   = mntp_pkg::ERR_SLASH;
            phase_nxt = mntp_pkg::PH_ERR;
          end
        end
        mntp_pkg::PH_FRAC1: begin
          if (is_digit) begin
            frac_nxt  = 7'(char_code[3:0]);
            phase_nxt = mntp_pkg::PH_FRAC2;
          end else begin
            err_nxt   = mntp_pkg::ERR_FRAC;
            phase_nxt = mntp_pkg::PH_ERR;
          end
        end
        mntp_pkg::PH_FRAC2: begin
          if (is_digit) begin
            frac_nxt  = 7'(frac_r * 7'd10 + 7'(char_code[3:0]));
            phase_nxt = mntp_pkg::PH_DOT;
          end else begin
            fall_dot = 1'b1;
          end
        end
        mntp_pkg::PH_DOT: fall_dot = 1'b1;
        mntp_pkg::PH_TIE: fall_tie = 1'b1;
        default: ;
      endcase

      if (fall_oct) begin
        if (char_code >= mntp_pkg::CH_TWO && char_code <= mntp_pkg::CH_EIGHT) begin
          oct_nxt   = char_code[3:0];
          phase_nxt = mntp_pkg::PH_SLASH;
        end else begin
          err_nxt   = mntp_pkg::ERR_OCT;
          phase_nxt = mntp_pkg::PH_ERR;
        end
      end
      if (fall_dot) begin
        if (char_code == mntp_pkg::CH_DOT) begin
          dot_nxt   = 1'b1;
          phase_nxt = mntp_pkg::PH_TIE;
        end else begin
          fall_tie = 1'b1;
        end
      end
      if (fall_tie) begin
        if (char_code == mntp_pkg::CH_TIE) begin
          tie_nxt = 1'b1;
        end
        phase_nxt = mntp_pkg::PH_DONE;
      end
    end
  end

  // Word end: a missing remainder reads as NUL
  always_comb begin
    end_err = err_nxt;
    if (err_nxt == mntp_pkg::ERR_NONE) begin
      priority case (phase_nxt)
        mntp_pkg::PH_LETTER: end_err = mntp_pkg::ERR_NAME;
        mntp_pkg::PH_ACC,
        mntp_pkg::PH_OCT:    end_err = mntp_pkg::ERR_OCT;
        mntp_pkg::PH_SLASH:  end_err = mntp_pkg::ERR_SLASH;
        mntp_pkg::PH_FRAC1:  end_err = mntp_pkg::ERR_FRAC;
        default: begin
          if (frac_nxt == '0) begin
            end_err = mntp_pkg::ERR_FRAC;
          end
        end
      endcase
    end
    push            = take && last_char;
    push_cmd.base   = base_nxt;
    push_cmd.oct    = oct_nxt;
    push_cmd.frac   = frac_nxt;
    push_cmd.dotted = dot_nxt;
    push_cmd.tied   = tie_nxt;
    push_cmd.err    = end_err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      phase_r  <= mntp_pkg::PH_LETTER;
      letter_r <= '0;
      base_r   <= '0;
      oct_r    <= '0;
      frac_r   <= '0;
      dot_r    <= 1'b0;
      tie_r    <= 1'b0;
      err_r    <= mntp_pkg::ERR_NONE;
    end else begin
      phase_r  <= phase_nxt;
      letter_r <= letter_nxt;
      base_r   <= base_nxt;
      oct_r    <= oct_nxt;
      frac_r   <= frac_nxt;
      dot_r    <= dot_nxt;
      tie_r    <= tie_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule

### rtl/mntp_fifo.sv
// Two-entry queue of parsed note words between front and back.
module mntp_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mntp_pkg::note_cmd_t push_cmd,
  input  logic                pop,
  output logic                full,
  output logic                not_empty,
  output mntp_pkg::note_cmd_t head
);

  mntp_pkg::note_cmd_t mem_r [2];
  logic                wr_ptr_r, rd_ptr_r;
  logic [1:0]          count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = 2'(count_r + 2'd1);
    end else if (pop && !push) begin
      count_nxt = 2'(count_r - 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_nxt;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty queue");

endmodule

### rtl/mntp_div.sv
// Iterative unsigned divider, two quotient bits a cycle.
module mntp_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mntp_pkg::div_req_t           req,
  output logic                         done,
  output logic [mntp_pkg::DIV_W-1:0]   quot
);

  logic [mntp_pkg::DIV_W-1:0]     num_r, num_nxt;
  logic [mntp_pkg::FRAC_W-1:0]    rem_r, rem_nxt;
  logic [mntp_pkg::FRAC_W-1:0]    den_r;
  logic [mntp_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           busy_r, done_r;
  logic [mntp_pkg::FRAC_W:0]      trial;

  assign done = done_r;
  assign quot = num_r;

  // Two restoring steps: shift in a numerator bit, subtract if it fits
  always_comb begin
    num_nxt = num_r;
    rem_nxt = rem_r;
    trial   = '0;
    for (int i = 0; i < 2; i++) begin
      trial = {rem_nxt, num_nxt[mntp_pkg::DIV_W-1]};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = mntp_pkg::FRAC_W'(trial - {1'b0, den_r});
        num_nxt = {num_nxt[mntp_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[mntp_pkg::FRAC_W-1:0];
        num_nxt = {num_nxt[mntp_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.num;
      rem_r <= '0;
      den_r <= req.den;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == mntp_pkg::DIV_CNT_W'(mntp_pkg::DIV_CYC - 1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= mntp_pkg::DIV_CNT_W'(cnt_r + 1'b1);
        if (cnt_r == mntp_pkg::DIV_CNT_W'(mntp_pkg::DIV_CYC - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r && req.den != '0)
    else $error("divider started while busy or by zero");

endmodule

### rtl/mntp_back.sv
// Back end: turns a parsed note word into frequency and durations.
module mntp_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_not_empty,
  input  mntp_pkg::note_cmd_t          q_head,
  input  logic [mntp_pkg::WN_W-1:0]    whole_note_ms,
  output logic                         q_pop,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic [mntp_pkg::FREQ_W-1:0]  res_freq,
  output logic [mntp_pkg::MS_W-1:0]    res_total,
  output logic [mntp_pkg::MS_W-1:0]    res_on,
  output logic [mntp_pkg::ERR_W-1:0]   res_err
);

  mntp_pkg::back_state_t          state_r, state_nxt;
  mntp_pkg::note_cmd_t            cmd_r;
  mntp_pkg::div_req_t             div_req;
  logic                           div_done;
  logic [mntp_pkg::DIV_W-1:0]     div_q;
  logic [mntp_pkg::FREQ_W-1:0]    freq_r, freq_calc;
  logic [mntp_pkg::MS_W-1:0]      total_r, on_r;
  logic [mntp_pkg::MS_W-1:0]      total_calc, on_calc;
  logic [mntp_pkg::WN_W-1:0]      q_ms;
  logic [mntp_pkg::MS_W+2:0]      times7;
  logic [mntp_pkg::HZ_NUM_W-1:0]  freq_num;
  logic [mntp_pkg::HZ_PROD_W-1:0] freq_prod;

  mntp_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .done (div_done),
    .quot (div_q)
  );

  // Pitch shifted left by the octave, over 100, by reciprocal multiply
  assign freq_num   = {8'b0, cmd_r.base} << cmd_r.oct;
  assign freq_prod  = freq_num * mntp_pkg::HZ_RECIP;
  assign freq_calc  = freq_prod[mntp_pkg::HZ_SHIFT+mntp_pkg::FREQ_W-1:mntp_pkg::HZ_SHIFT];

  assign q_ms       = div_q;
  assign total_calc = cmd_r.dotted ? mntp_pkg::MS_W'({1'b0, q_ms} + {2'b0, q_ms[mntp_pkg::WN_W-1:1]})
                                   : {1'b0, q_ms};
  assign times7     = {total_r, 3'b000} - {3'b000, total_r};
  assign on_calc    = cmd_r.tied ? total_r : times7[mntp_pkg::MS_W+2:3];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mntp_pkg::BK_IDLE: begin
        if (q_not_empty) begin
          state_nxt = (q_head.err != mntp_pkg::ERR_NONE) ? mntp_pkg::BK_OUT
                                                         : mntp_pkg::BK_DIVT;
        end
      end
      mntp_pkg::BK_DIVT: if (div_done) state_nxt = mntp_pkg::BK_FIN;
      mntp_pkg::BK_FIN:  state_nxt = mntp_pkg::BK_OUT;
      mntp_pkg::BK_OUT:  if (res_ready) state_nxt = mntp_pkg::BK_IDLE;
      default:           state_nxt = mntp_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop         = (state_r == mntp_pkg::BK_IDLE) && q_not_empty;
    res_valid     = (state_r == mntp_pkg::BK_OUT);
    // divide the whole note by the fraction as a clean word leaves the queue
    div_req.start = q_pop && (q_head.err == mntp_pkg::ERR_NONE);
    div_req.num   = whole_note_ms;
    div_req.den   = q_head.frac;
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      mntp_pkg::BK_IDLE: begin
        if (q_pop) begin
          cmd_r   <= q_head;
          freq_r  <= '0;
          total_r <= '0;
          on_r    <= '0;
        end
      end
      mntp_pkg::BK_DIVT: begin
        if (div_done) begin
          total_r <= total_calc;
          freq_r  <= freq_calc;
        end
      end
      mntp_pkg::BK_FIN:  on_r <= on_calc;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mntp_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign res_freq  = freq_r;
  assign res_total = total_r;
  assign res_on    = on_r;
  assign res_err   = cmd_r.err;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_err != mntp_pkg::ERR_NONE |-> res_freq == '0 && res_total == '0 &&
                                                   res_on == '0)
    else $error("error word carries nonzero results");
  a_on_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> res_on <= res_total)
    else $error("sounding time exceeds slot length");
  a_freq_fits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mntp_pkg::BK_DIVT |->
      freq_prod[mntp_pkg::HZ_PROD_W-1:mntp_pkg::HZ_SHIFT+mntp_pkg::FREQ_W] == '0)
    else $error("frequency overflows");

endmodule

### rtl/music_note_text_parser.sv
// Top level of the note word parser.
//
// in_ch takes one ASCII character per transfer (char_code), with last_char set
// on the final character of a note word such as C#4/8._ or R/2. out_ch
// gives one result per note word: frequency_hz, slot_ms, on_ms and
// error_code. cfg_we/cfg_wdata write whole_note_ms, the whole note length
// in milliseconds (reset 2000); write it only while no word is in flight.
//
// Characters are taken one a cycle while the two-entry word queue has room.
// On the last character the parsed word enters the queue. The back end
// divides whole_note_ms by the fraction two quotient bits a cycle and
// scales the pitch by a reciprocal multiply; it then derives the sounding
// time and shows the result. An error word skips the divider and shows a
// zero result. The back end takes one word at a time and pops the next
// only after the result is taken.
//
// Reset clears the parse state and the queue and sets whole_note_ms to
// 2000. A result stays on out_ch until taken; while out_ch stalls the
// front keeps taking characters until the queue fills, then holds ready low.
module music_note_text_parser (
  input  logic                      clk,
  input  logic                      rst_n,
  mntp_char_if.sink                 in_ch,
  mntp_note_if.source               out_ch,
  input  logic                      cfg_we,
  input  logic [mntp_pkg::WN_W-1:0] cfg_wdata
);

  logic [mntp_pkg::WN_W-1:0] whole_note_ms_r;
  logic                      push, pop, q_full, q_not_empty;
  mntp_pkg::note_cmd_t       push_cmd, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      whole_note_ms_r <= mntp_pkg::WN_RESET;
    end else if (cfg_we) begin
      whole_note_ms_r <= cfg_wdata;
    end
  end

  mntp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .char_valid(in_ch.valid),
    .char_code (in_ch.char_code),
    .last_char (in_ch.last_char),
    .q_full    (q_full),
    .char_ready(in_ch.ready),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  mntp_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (q_full),
    .not_empty(q_not_empty),
    .head     (q_head)
  );

  mntp_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_not_empty  (q_not_empty),
    .q_head       (q_head),
    .whole_note_ms(whole_note_ms_r),
    .q_pop        (pop),
    .res_valid    (out_ch.valid),
    .res_ready    (out_ch.ready),
    .res_freq     (out_ch.frequency_hz),
    .res_total    (out_ch.slot_ms),
    .res_on       (out_ch.on_ms),
    .res_err      (out_ch.error_code)
  );

endmodule

### tb/music_note_text_parser_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the note word parser: directed words, then random word streams.
module music_note_text_parser_tb;

  typedef struct packed {
    logic [mntp_pkg::FREQ_W-1:0] freq_hz;
    logic [mntp_pkg::MS_W-1:0]   slot_ms;
    logic [mntp_pkg::MS_W-1:0]   on_ms;
    logic [mntp_pkg::ERR_W-1:0]  err;
  } note_res_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_we;
  logic [mntp_pkg::WN_W-1:0] cfg_wdata;

  mntp_char_if char_bus ();
  mntp_note_if note_bus ();

  music_note_text_parser uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (char_bus),
    .out_ch   (note_bus),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted parser state
  mntp_pkg::phase_t             ps_phase;
  int                           ps_letter;
  logic [mntp_pkg::PITCH_W-1:0] ps_pitch;
  logic [mntp_pkg::OCT_W-1:0]   ps_oct;
  logic [mntp_pkg::FRAC_W-1:0]  ps_frac;
  logic                         ps_dot;
  logic                         ps_tie;
  logic [mntp_pkg::ERR_W-1:0]   ps_err;
  logic [mntp_pkg::WN_W-1:0]    whole_ms;

  note_res_t note_q[$];
  int        mismatch_cnt = 0;
  int        src_idle_pct = 0;
  int        sink_stall_pct = 0;

  function automatic logic [mntp_pkg::PITCH_W-1:0] pitch_of(input int letter,
                                                            input logic [1:0] col);
    logic [mntp_pkg::PITCH_W-1:0] row [3];
    case (letter)
      0: row = '{12'd2750, 12'd2596, 12'd2914};
      1: row = '{12'd3087, 12'd2914, 12'd0};
      2: row = '{12'd1635, 12'd0,    12'd1732};
      3: row = '{12'd1835, 12'd1732, 12'd1945};
      4: row = '{12'd2060, 12'd1945, 12'd0};
      5: row = '{12'd2183, 12'd0,    12'd2312};
      6: row = '{12'd2450, 12'd2312, 12'd2596};
      default: row = '{12'd0, 12'd0, 12'd0};
    endcase
    return row[col];
  endfunction

  function automatic void clear_word();
    ps_phase  = mntp_pkg::PH_LETTER;
    ps_letter = 0;
    ps_pitch  = '0;
    ps_oct    = '0;
    ps_frac   = '0;
    ps_dot    = 1'b0;
    ps_tie    = 1'b0;
    ps_err    = mntp_pkg::ERR_NONE;
  endfunction

  function automatic void flag_error(input logic [mntp_pkg::ERR_W-1:0] code);
    if (ps_err == mntp_pkg::ERR_NONE) ps_err = code;
    ps_phase = mntp_pkg::PH_ERR;
  endfunction

  function automatic void parse_char(input logic [7:0] c);
    bit                           again;
    logic [mntp_pkg::PITCH_W-1:0] p;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (ps_phase)
        mntp_pkg::PH_LETTER: begin
          if (c >= mntp_pkg::CH_A && c <= mntp_pkg::CH_G) begin
            ps_letter = int'(c - mntp_pkg::CH_A);
            ps_pitch  = pitch_of(ps_letter, mntp_pkg::ACC_NAT);
            ps_phase  = mntp_pkg::PH_ACC;
          end else if (c == mntp_pkg::CH_R) begin
            ps_pitch = '0;
            ps_phase = mntp_pkg::PH_SLASH;
          end else begin
            flag_error(mntp_pkg::ERR_NAME);
          end
        end
        mntp_pkg::PH_ACC: begin
          if (c == mntp_pkg::CH_FLAT || c == mntp_pkg::CH_SHARP) begin
            p = pitch_of(ps_letter, (c == mntp_pkg::CH_FLAT) ? mntp_pkg::ACC_FLAT
                                                             : mntp_pkg::ACC_SHARP);
            if (p == '0) begin
              flag_error(mntp_pkg::ERR_ACC);
            end else begin
              ps_pitch = p;
              ps_phase = mntp_pkg::PH_OCT;
            end
          end else begin
            // no accidental: read this character as the octave
            ps_phase = mntp_pkg::PH_OCT;
            again    = 1'b1;
          end
        end
        mntp_pkg::PH_OCT: begin
          if (c >= mntp_pkg::CH_TWO && c <= mntp_pkg::CH_EIGHT) begin
            ps_oct   = mntp_pkg::OCT_W'(c - mntp_pkg::CH_ZERO);
            ps_phase = mntp_pkg::PH_SLASH;
          end else begin
            flag_error(mntp_pkg::ERR_OCT);
          end
        end
        mntp_pkg::PH_SLASH: begin
          if (c == mntp_pkg::CH_SLASH) ps_phase = mntp_pkg::PH_FRAC1;
          else flag_error(mntp_pkg::ERR_SLASH);
        end
        mntp_pkg::PH_FRAC1: begin
          if (c >= mntp_pkg::CH_ZERO && c <= mntp_pkg::CH_NINE) begin
            ps_frac  = mntp_pkg::FRAC_W'(c - mntp_pkg::CH_ZERO);
            ps_phase = mntp_pkg::PH_FRAC2;
          end else begin
            flag_error(mntp_pkg::ERR_FRAC);
          end
        end
        mntp_pkg::PH_FRAC2: begin
          ps_phase = mntp_pkg::PH_DOT;
          if (c >= mntp_pkg::CH_ZERO && c <= mntp_pkg::CH_NINE)
            ps_frac = mntp_pkg::FRAC_W'(ps_frac * 10 + (c - mntp_pkg::CH_ZERO));
          else again = 1'b1;
        end
        mntp_pkg::PH_DOT: begin
          ps_phase = mntp_pkg::PH_TIE;
          if (c == mntp_pkg::CH_DOT) ps_dot = 1'b1;
          else again = 1'b1;
        end
        mntp_pkg::PH_TIE: begin
          if (c == mntp_pkg::CH_TIE) ps_tie = 1'b1;
          ps_phase = mntp_pkg::PH_DONE;
        end
        default: ;
      endcase
    end
  endfunction

  // Advance the predicted parser by one accepted character; queue a result on the last one
  function automatic void track_note_char(input logic [7:0] c, input logic last);
    logic [31:0] f;
    logic [31:0] t;
    logic [31:0] o;
    note_res_t   res;
    if (ps_phase != mntp_pkg::PH_ERR) parse_char(c);
    if (last) begin
      f = '0;
      t = '0;
      o = '0;
      case (ps_phase)
        mntp_pkg::PH_LETTER:                 flag_error(mntp_pkg::ERR_NAME);
        mntp_pkg::PH_ACC, mntp_pkg::PH_OCT:  flag_error(mntp_pkg::ERR_OCT);
        mntp_pkg::PH_SLASH:                  flag_error(mntp_pkg::ERR_SLASH);
        mntp_pkg::PH_FRAC1:                  flag_error(mntp_pkg::ERR_FRAC);
        default: ;
      endcase
      if (ps_err == mntp_pkg::ERR_NONE && ps_frac == '0) flag_error(mntp_pkg::ERR_FRAC);
      if (ps_err == mntp_pkg::ERR_NONE) begin
        if (ps_pitch != '0) f = (32'(ps_pitch) << ps_oct) / 32'd100;
        t = 32'(whole_ms) / 32'(ps_frac);
        if (ps_dot) t = (32'd3 * t) / 32'd2;
        o = ps_tie ? t : (32'd7 * t) / 32'd8;
      end
      res.freq_hz = f[mntp_pkg::FREQ_W-1:0];
      res.slot_ms = t[mntp_pkg::MS_W-1:0];
      res.on_ms   = o[mntp_pkg::MS_W-1:0];
      res.err     = ps_err;
      note_q.push_back(res);
      clear_word();
    end
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  task automatic check_note();
    note_res_t want;
    if (note_q.size() == 0) begin
      report_mismatch("unexpected result, error_code", note_bus.error_code, 0);
      return;
    end
    want = note_q.pop_front();
    if (note_bus.frequency_hz !== want.freq_hz)
      report_mismatch("frequency_hz", note_bus.frequency_hz, want.freq_hz);
    if (note_bus.slot_ms !== want.slot_ms)
      report_mismatch("slot_ms", note_bus.slot_ms, want.slot_ms);
    if (note_bus.on_ms !== want.on_ms)
      report_mismatch("on_ms", note_bus.on_ms, want.on_ms);
    if (note_bus.error_code !== want.err)
      report_mismatch("error_code", note_bus.error_code, want.err);
  endtask

  // Result side: check each accepted word, then pick the next ready
  always @(posedge clk) begin
    if (rst_n) begin
      if (note_bus.valid === 1'b1 && note_bus.ready === 1'b1) check_note();
      note_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end else begin
      note_bus.ready <= 1'b0;
    end
  end

  task automatic send_char(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      char_bus.valid <= 1'b0;
      @(posedge clk);
    end
    char_bus.valid     <= 1'b1;
    char_bus.char_code <= c;
    char_bus.last_char <= last;
    @(posedge clk);
    while (char_bus.ready !== 1'b1) @(posedge clk);
    track_note_char(c, last);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // Drop valid, drain all results, then let the back end go quiet
  task automatic settle_block();
    char_bus.valid <= 1'b0;
    while (note_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_whole_note(input logic [mntp_pkg::WN_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    whole_ms = v;
  endtask

  function automatic logic [7:0] noise_char();
    logic [7:0] pick [12];
    pick = '{mntp_pkg::CH_A, mntp_pkg::CH_G, mntp_pkg::CH_R, mntp_pkg::CH_FLAT,
             mntp_pkg::CH_SHARP, mntp_pkg::CH_TWO, mntp_pkg::CH_EIGHT, mntp_pkg::CH_ZERO,
             mntp_pkg::CH_NINE, mntp_pkg::CH_SLASH, mntp_pkg::CH_DOT, mntp_pkg::CH_TIE};
    if ($urandom_range(1)) return 8'($urandom_range(255));
    return pick[$urandom_range(11)];
  endfunction

  task automatic send_random_word(output int n_sent);
    logic [7:0] w[$];
    int         cut;
    int         n;
    if ($urandom_range(99) < 75) begin
      if ($urandom_range(7) == 0) begin
        w.push_back(mntp_pkg::CH_R);
      end else begin
        w.push_back(8'(mntp_pkg::CH_A + $urandom_range(6)));
        case ($urandom_range(4))
          0: w.push_back(mntp_pkg::CH_FLAT);
          1: w.push_back(mntp_pkg::CH_SHARP);
          default: ;
        endcase
        if ($urandom_range(15) == 0) w.push_back(8'(mntp_pkg::CH_ZERO + $urandom_range(9)));
        else w.push_back(8'(mntp_pkg::CH_TWO + $urandom_range(6)));
      end
      if ($urandom_range(19) != 0) w.push_back(mntp_pkg::CH_SLASH);
      w.push_back(8'(mntp_pkg::CH_ZERO + $urandom_range(9)));
      if ($urandom_range(1)) w.push_back(8'(mntp_pkg::CH_ZERO + $urandom_range(9)));
      if ($urandom_range(2) == 0) w.push_back(mntp_pkg::CH_DOT);
      if ($urandom_range(2) == 0) w.push_back(mntp_pkg::CH_TIE);
      if ($urandom_range(7) == 0) w.push_back(noise_char());
      // end the word early now and then
      if ($urandom_range(9) == 0) begin
        cut = $urandom_range(w.size() - 1);
        while (w.size() > cut + 1) void'(w.pop_back());
      end
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) w.push_back(noise_char());
    end
    foreach (w[i]) send_char(w[i], i == w.size() - 1);
    n_sent = w.size();
  endtask

  task automatic run_random_words(input int n_chars);
    int sent;
    int n;
    sent = 0;
    while (sent < n_chars) begin
      send_random_word(n);
      sent += n;
    end
  endtask

  task automatic test_directed_words();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_text("R/1");
    send_text("B#");
    send_text("Db8/99._Z");
    send_text("A2/0");
    send_char(8'hFF, 1'b1);
    send_char("C", 1'b0);
    send_char(8'h00, 1'b1);
    send_text("G4x");
    send_text("E");
    send_text("F3/");
    settle_block();
  endtask

  task automatic test_streaming();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    set_whole_note({mntp_pkg::WN_W{1'b1}});
    run_random_words(450);
    settle_block();
  endtask

  task automatic test_sender_gaps();
    src_idle_pct   = 84;
    sink_stall_pct = 0;
    set_whole_note(18'd1);
    run_random_words(400);
    settle_block();
  endtask

  task automatic test_receiver_stalls();
    src_idle_pct   = 0;
    sink_stall_pct = 84;
    set_whole_note(mntp_pkg::WN_W'($urandom_range(1, 262143)));
    run_random_words(400);
    settle_block();
  endtask

  task automatic test_mixed_idle();
    src_idle_pct   = 29;
    sink_stall_pct = 29;
    set_whole_note(mntp_pkg::WN_W'($urandom_range(1, 5000)));
    run_random_words(400);
    settle_block();
  endtask

  initial begin
    int waited;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    char_bus.valid     = 1'b0;
    char_bus.char_code = '0;
    char_bus.last_char = 1'b0;
    whole_ms           = mntp_pkg::WN_RESET;
    clear_word();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_words();
    test_streaming();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idle();

    char_bus.valid <= 1'b0;
    waited = 0;
    while (note_q.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (note_q.size() != 0) report_mismatch("results never delivered", 0, note_q.size());

    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
